### rtl/rmtt_pkg.sv
package rmtt_pkg;

    localparam int IN_W        = 104;
    localparam int OUT_W       = 112;
    localparam int NUM_TRACKED = 28;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    localparam logic [2:0] FUNC_MEM_READ  = 3'd0;
    localparam logic [2:0] FUNC_MEM_WRITE = 3'd1;
    localparam logic [2:0] FUNC_REG_MOVE  = 3'd2;
    localparam logic [2:0] FUNC_RANGE     = 3'd3;
    localparam logic [2:0] FUNC_LEAK      = 3'd4;

    localparam logic [4:0] REG_OTHER = 5'd28;
    localparam logic [4:0] REG_NONE  = 5'd29;

    localparam logic [3:0] EV_IGNORED   = 4'd0;
    localparam logic [3:0] EV_REG_TAINT = 4'd1;
    localparam logic [3:0] EV_ALREADY   = 4'd2;
    localparam logic [3:0] EV_UNTRACK   = 4'd3;
    localparam logic [3:0] EV_REG_FREE  = 4'd4;
    localparam logic [3:0] EV_MEM_TAINT = 4'd5;
    localparam logic [3:0] EV_MEM_FREE  = 4'd6;
    localparam logic [3:0] EV_LEAK      = 4'd7;
    localparam logic [3:0] EV_NO_LEAK   = 4'd8;
    localparam logic [3:0] EV_FULL      = 4'd9;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_SCAN,
        KIND_RANGE,
        KIND_LEAK
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_RINS,
        ST_RNEXT,
        ST_LEMIT,
        ST_LFIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic cmp;
        logic idx_inc;
        logic ins;
        logic off_inc;
        logic emit_pend;
        logic emit_final;
        logic fin;
    } cmd_t;

    typedef struct packed {
        kind_t in_kind;
        kind_t kind;
        logic  last_entry;
        logic  hit;
        logic  leak_hit;
        logic  pending;
        logic  free_found;
        logic  off_last;
        logic  cap_next;
        logic  out_free;
    } stat_t;

    function automatic logic [4:0] chain_end(input logic [4:0] r);
        logic [4:0] e;
        if (r < 5'd5) e = 5'd5;
        else if (r < 5'd10) e = 5'd10;
        else if (r < 5'd15) e = 5'd15;
        else if (r < 5'd20) e = 5'd20;
        else if (r < 5'd24) e = 5'd24;
        else e = 5'd28;
        return e;
    endfunction

    function automatic logic [NUM_TRACKED-1:0] chain_mask(input logic [4:0] r);
        logic [NUM_TRACKED-1:0] m;
        logic [4:0] e;
        e = chain_end(r);
        for (int j = 0; j < NUM_TRACKED; j++) begin
            m[j] = (5'(j) >= r) && (5'(j) < e);
        end
        return m;
    endfunction

endpackage

### rtl/register_memory_taint_tracker.sv
// register and memory taint tracker
// s_ channel: one beat per instruction event (memory read or write, register
// move, taint range, leak check); m_ channel: result beats, tlast on the
// final beat of each input beat. a leak check gives one beat per tainted
// address in its range (at most 64), otherwise one beat per input.
// an input beat is taken only while the block is idle; it may be taken while
// the previous result still waits in the output register.
// direct events (register moves, empty ranges, ignored codes and operand
// counts) put out their beat without a table walk; memory reads and writes
// walk the whole address table; a taint range rescans the table for each
// byte of the range, up to a hit; a leak check walks the table once and
// puts out its addresses as it finds them.
// all table walks go through the single read port.
// reset clears register taint and all table valid bits at once.
// a stalled receiver holds the output beat; the walk pauses when a result
// beat is ready and the output register is still full.
module register_memory_taint_tracker
    import rmtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // func, operand_count, reg_a, reg_b, address, length
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // event_res, leaked_address, inserted_count, taint_mask
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    rmtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmtt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/rmtt_ctrl.sv
module rmtt_ctrl
    import rmtt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (stat.in_kind)
                        KIND_DIRECT: state_next = ST_FIN;
                        default:     state_next = ST_RD;
                    endcase
                end
            end
            ST_RD: state_next = ST_CMP;
            ST_CMP: begin
                case (stat.kind)
                    KIND_RANGE: begin
                        if (stat.hit) state_next = ST_RNEXT;
                        else if (stat.last_entry) state_next = ST_RINS;
                        else state_next = ST_RD;
                    end
                    KIND_LEAK: begin
                        if (stat.leak_hit && stat.pending) state_next = ST_LEMIT;
                        else if (stat.leak_hit && stat.cap_next) state_next = ST_LFIN;
                        else if (stat.last_entry) state_next = ST_LFIN;
                        else state_next = ST_RD;
                    end
                    default: begin
                        if (stat.last_entry) state_next = ST_FIN;
                        else state_next = ST_RD;
                    end
                endcase
            end
            ST_RINS:  state_next = stat.free_found ? ST_RNEXT : ST_FIN;
            ST_RNEXT: state_next = stat.off_last ? ST_FIN : ST_RD;
            ST_LEMIT: begin
                if (stat.out_free) begin
                    if (stat.cap_next || stat.last_entry) state_next = ST_LFIN;
                    else state_next = ST_RD;
                end
            end
            ST_LFIN: if (stat.out_free) state_next = ST_IDLE;
            ST_FIN:  if (stat.out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CMP: begin
                cmd.cmp = 1'b1;
                case (stat.kind)
                    KIND_RANGE: cmd.idx_inc = !stat.hit && !stat.last_entry;
                    // first hit is held and the walk moves on to the next entry
                    KIND_LEAK: cmd.idx_inc = !stat.last_entry &&
                        !(stat.leak_hit && (stat.pending || stat.cap_next));
                    default: cmd.idx_inc = !stat.last_entry;
                endcase
            end
            ST_RINS:  cmd.ins = 1'b1;
            ST_RNEXT: cmd.off_inc = !stat.off_last;
            ST_LEMIT: begin
                cmd.emit_pend = stat.out_free;
                cmd.idx_inc   = stat.out_free && !stat.cap_next && !stat.last_entry;
            end
            ST_LFIN: cmd.emit_final = stat.out_free;
            ST_FIN:  cmd.fin = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/rmtt_datapath.sv
module rmtt_datapath
    import rmtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [63:0] mem [TABLE_DEPTH];
    logic [63:0] rd_q;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic [2:0]  func_reg;
    logic        two_reg;
    logic [4:0]  ra_reg, rb_reg;
    logic [63:0] addr_reg;
    logic [15:0] len_reg;
    kind_t       kind_reg;

    logic [IDX_W-1:0] idx_reg, match_idx_reg, free_idx_reg;
    logic [15:0] off_reg, cnt_reg;
    logic        found_reg, free_found_reg, pending_reg, full_reg;
    logic [63:0] pend_reg;
    logic [CNT_W-1:0] n_reg;
    logic [NUM_TRACKED-1:0] taint_reg, taint_next;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic              m_last_reg;

    logic [2:0]  in_func;
    logic [4:0]  in_ra, in_rb;
    logic [15:0] in_len;
    kind_t       in_kind;

    logic [63:0] target;
    logic        cur_valid, hit, leak_hit;
    logic        out_free;
    logic        we;
    logic [IDX_W-1:0] waddr;
    logic [63:0] wdata;
    logic [3:0]  fin_ev;
    logic        ta, tb;

    function automatic logic [4:0] norm_reg(input logic [4:0] r);
        return (r > REG_NONE) ? REG_OTHER : r;
    endfunction

    assign in_func = s_tdata[2:0];
    assign in_ra   = norm_reg(s_tdata[11:7]);
    assign in_rb   = norm_reg(s_tdata[16:12]);
    assign in_len  = s_tdata[96:81];

    always_comb begin
        case (in_func)
            FUNC_MEM_READ, FUNC_MEM_WRITE:
                in_kind = (s_tdata[6:3] == 4'd2) ? KIND_SCAN : KIND_DIRECT;
            FUNC_RANGE: in_kind = (in_len != 16'd0) ? KIND_RANGE : KIND_DIRECT;
            FUNC_LEAK:  in_kind = KIND_LEAK;
            default:    in_kind = KIND_DIRECT;
        endcase
    end

    assign target    = addr_reg + {48'd0, off_reg};
    assign cur_valid = valid_reg[idx_reg];
    assign hit       = cur_valid && (rd_q == target);
    // unsigned wrap makes the window test one subtract and compare
    assign leak_hit  = cur_valid && ((rd_q - addr_reg) < {48'd0, len_reg});
    assign out_free  = !m_valid_reg || m_tready;

    assign ta = (ra_reg < REG_OTHER) && taint_reg[ra_reg];
    assign tb = (rb_reg < REG_OTHER) && taint_reg[rb_reg];

    always_comb begin
        stat.in_kind    = in_kind;
        stat.kind       = kind_reg;
        stat.last_entry = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        stat.hit        = hit;
        stat.leak_hit   = leak_hit;
        stat.pending    = pending_reg;
        stat.free_found = free_found_reg;
        stat.off_last   = (off_reg == len_reg - 16'd1);
        stat.cap_next   = (n_reg == CNT_W'(MAX_RESULTS - 1));
        stat.out_free   = out_free;
    end

    // final result of a single-result item, with its state update, and the table insert of a taint range
    always_comb begin
        fin_ev     = EV_IGNORED;
        taint_next = taint_reg;
        valid_next = valid_reg;
        we         = 1'b0;
        waddr      = free_idx_reg;
        wdata      = target;
        case (func_reg)
            FUNC_MEM_READ: begin
                if (two_reg) begin
                    if (found_reg) begin
                        if (ta) fin_ev = EV_ALREADY;
                        else if (ra_reg >= REG_OTHER) fin_ev = EV_UNTRACK;
                        else begin
                            taint_next = taint_reg | chain_mask(ra_reg);
                            fin_ev     = EV_REG_TAINT;
                        end
                    end else if (ta) begin
                        taint_next = taint_reg & ~chain_mask(ra_reg);
                        fin_ev     = EV_REG_FREE;
                    end
                end
            end
            FUNC_MEM_WRITE: begin
                if (two_reg) begin
                    if (found_reg) begin
                        if (!ta) begin
                            valid_next[match_idx_reg] = 1'b0;
                            fin_ev = EV_MEM_FREE;
                        end
                    end else if (ta) begin
                        if (free_found_reg) begin
                            valid_next[free_idx_reg] = 1'b1;
                            we     = 1'b1;
                            fin_ev = EV_MEM_TAINT;
                        end else begin
                            fin_ev = EV_FULL;
                        end
                    end
                end
            end
            FUNC_REG_MOVE: begin
                if (two_reg && rb_reg != REG_NONE) begin
                    if (tb && !ta) begin
                        taint_next = taint_reg & ~chain_mask(rb_reg);
                        fin_ev     = EV_REG_FREE;
                    end else if (!tb && ta) begin
                        if (rb_reg >= REG_OTHER) fin_ev = EV_UNTRACK;
                        else begin
                            taint_next = taint_reg | chain_mask(rb_reg);
                            fin_ev     = EV_REG_TAINT;
                        end
                    end
                end
            end
            FUNC_RANGE: fin_ev = full_reg ? EV_FULL : EV_MEM_TAINT;
            default: fin_ev = EV_IGNORED;
        endcase
        if (!cmd.fin) begin
            taint_next = taint_reg;
            valid_next = valid_reg;
            we         = 1'b0;
        end
        if (cmd.ins && free_found_reg) begin
            valid_next[free_idx_reg] = 1'b1;
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            two_reg  <= (s_tdata[6:3] == 4'd2);
            ra_reg   <= in_ra;
            rb_reg   <= in_rb;
            addr_reg <= s_tdata[80:17];
            len_reg  <= in_len;
        end
        if (cmd.cmp) begin
            if (hit && !found_reg) match_idx_reg <= idx_reg;
            if (!cur_valid && !free_found_reg) free_idx_reg <= idx_reg;
        end
        if (cmd.cmp && leak_hit && !pending_reg) begin
            pend_reg <= rd_q;
        end else if (cmd.emit_pend) begin
            pend_reg <= rd_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg       <= KIND_DIRECT;
            valid_reg      <= '0;
            taint_reg      <= '0;
            idx_reg        <= '0;
            off_reg        <= '0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pending_reg    <= 1'b0;
            full_reg       <= 1'b0;
            n_reg          <= '0;
        end else begin
            valid_reg <= valid_next;
            taint_reg <= taint_next;
            if (cmd.load) begin
                kind_reg       <= in_kind;
                idx_reg        <= '0;
                off_reg        <= '0;
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                pending_reg    <= 1'b0;
                full_reg       <= 1'b0;
                n_reg          <= '0;
            end
            if (cmd.idx_inc) idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.cmp) begin
                if (hit) found_reg <= 1'b1;
                if (!cur_valid) free_found_reg <= 1'b1;
                if (leak_hit && !pending_reg) begin
                    pending_reg <= 1'b1;
                    n_reg       <= n_reg + CNT_W'(1);
                end
            end
            if (cmd.emit_pend) n_reg <= n_reg + CNT_W'(1);
            if (cmd.ins) begin
                if (free_found_reg) cnt_reg <= cnt_reg + 16'd1;
                else full_reg <= 1'b1;
            end
            // next address of the range rescans from the first entry
            if (cmd.off_inc) begin
                off_reg        <= off_reg + 16'd1;
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_pend || cmd.emit_final || cmd.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_pend) begin
            m_data_reg <= {taint_reg, 16'd0, pend_reg, EV_LEAK};
            m_last_reg <= 1'b0;
        end else if (cmd.emit_final) begin
            if (pending_reg) m_data_reg <= {taint_reg, 16'd0, pend_reg, EV_LEAK};
            else m_data_reg <= {taint_reg, 16'd0, 64'd0, EV_NO_LEAK};
            m_last_reg <= 1'b1;
        end else if (cmd.fin) begin
            m_data_reg <= {taint_next, cnt_reg, 64'd0, fin_ev};
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
